// File: design/spectrum_peak_decimator_top_macros.svh
// ---------------------------------------------------------------------------
// Spectrum peak decimator assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SPECTRUM_PEAK_DECIMATOR_TOP_MACROS_SVH
`define SPECTRUM_PEAK_DECIMATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SPD_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("spd assertion failed");
`define SPD_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("spd assertion failed");
`else
`define SPD_ASSERT(label, clk, rst, cond)
`define SPD_ASSERT_NEXT(label, clk, rst, trig, cond)
`endif

`endif

// File: design/spd_pkg.sv
// ---------------------------------------------------------------------------
// Spectrum peak decimator package
// Frame constants, register indexes and pixel helpers.
// ---------------------------------------------------------------------------
package spd_pkg;

  localparam int unsigned BINS        = 4096;
  localparam int unsigned MAX_COLUMNS = 4096;
  localparam int unsigned COL_LIMIT   = (BINS < MAX_COLUMNS) ? BINS : MAX_COLUMNS;

  localparam int unsigned CNT_W  = 13;
  localparam int unsigned COL_W  = 12;
  localparam int unsigned PWR_W  = 16;
  localparam int unsigned OFS_W  = 16;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned ACC_W  = 25;
  localparam int unsigned SUM_W  = 18;
  localparam int unsigned CFG_W  = 16;

  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [COL_W-1:0]        column_t;
  typedef logic signed [PWR_W-1:0] power_t;
  typedef logic signed [OFS_W-1:0] offset_t;
  typedef logic [PIX_W-1:0]        pixel_t;
  typedef logic [ACC_W-1:0]        acc_t;

  typedef enum logic [0:0] {
    REG_COLUMN_COUNT   = 1'b0,
    REG_DISPLAY_OFFSET = 1'b1
  } reg_index_t;

  localparam count_t  COLUMN_COUNT_RESET   = count_t'(4096);
  localparam offset_t DISPLAY_OFFSET_RESET = offset_t'(-768);
  localparam power_t  PEAK_FLOOR           = power_t'(-32768);
  localparam acc_t    BINS_ACC             = acc_t'(BINS);
  localparam count_t  COL_LIMIT_CNT        = count_t'(COL_LIMIT);

  function automatic count_t effective_columns(input count_t cc);
    count_t c;
    c = cc;
    if (c == '0) c = count_t'(1);
    if (c > COL_LIMIT_CNT) c = COL_LIMIT_CNT;
    return c;
  endfunction

  // -(peak + offset) / 16, truncated toward zero, clamped to 0..255
  function automatic pixel_t make_pixel(input power_t peak, input offset_t ofs);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] neg;
    pixel_t                  pix;
    sum = SUM_W'(peak) + SUM_W'(ofs);
    neg = -sum;
    if (neg[SUM_W-1]) pix = '0;
    else if (|neg[SUM_W-2:PIX_W+4]) pix = '1;
    else pix = neg[PIX_W+3:4];
    return pix;
  endfunction

endpackage

// File: design/spectrum_peak_decimator_top.sv
// ---------------------------------------------------------------------------
// Spectrum peak decimator
// Max-pools a spectrum frame into display columns and emits one byte per
// column, negated, calibrated and saturated.
// ---------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       sink       in_valid/in_ready    power_db, frame_start
// out      source     out_valid/out_ready  pixel_value, column_index, last_column
// cfg      sink       cfg_we               cfg_index, cfg_data
//
// One item per cycle while the output is not stalled: input register, then
// one stage of compare, max and boundary add feeding the result register.
// Reset sets column_count to 4096, display_offset to -48 dB and the frame
// to bin 0. A stalled result holds the result register; the input register
// keeps taking items until it too is full.
// ---------------------------------------------------------------------------
`include "spectrum_peak_decimator_top_macros.svh"

module spectrum_peak_decimator_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  spd_pkg::power_t       power_db,
  input  logic                  frame_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output spd_pkg::pixel_t       pixel_value,
  output spd_pkg::column_t      column_index,
  output logic                  last_column,
  input  logic                  cfg_we,
  input  spd_pkg::reg_index_t   cfg_index,
  input  logic [spd_pkg::CFG_W-1:0] cfg_data
);
  import spd_pkg::*;

  count_t  column_count;
  offset_t display_offset;

  logic    s1_valid;
  power_t  s1_power;
  logic    s1_start;
  logic    advance;

  column_t current_column;
  power_t  running_peak;
  acc_t    bin_scaled_acc;
  acc_t    column_boundary_acc;

  column_t current_column_next;
  power_t  running_peak_next;
  acc_t    bin_scaled_acc_next;
  acc_t    column_boundary_acc_next;

  count_t  eff_cols;
  column_t col_base;
  power_t  peak_base;
  power_t  peak_upd;
  acc_t    bsa_base;
  acc_t    cba_base;
  logic    col_end;
  logic    col_last;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign eff_cols = effective_columns(column_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= COLUMN_COUNT_RESET;
      display_offset <= DISPLAY_OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMN_COUNT:   column_count   <= cfg_data[CNT_W-1:0];
        REG_DISPLAY_OFFSET: display_offset <= offset_t'(cfg_data[OFS_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_power <= power_db;
      s1_start <= frame_start;
    end
  end

  always_comb begin
    col_base  = s1_start ? '0 : current_column;
    peak_base = s1_start ? PEAK_FLOOR : running_peak;
    bsa_base  = s1_start ? acc_t'({eff_cols, 1'b0}) : bin_scaled_acc;
    cba_base  = s1_start ? BINS_ACC : column_boundary_acc;
    peak_upd  = (s1_power > peak_base) ? s1_power : peak_base;
    col_end   = bsa_base > cba_base;
    col_last  = (count_t'(col_base) + count_t'(1)) >= eff_cols;

    current_column_next      = col_base;
    running_peak_next        = peak_upd;
    bin_scaled_acc_next      = bsa_base + acc_t'(eff_cols);
    column_boundary_acc_next = cba_base;
    if (col_end) begin
      if (col_last) begin
        current_column_next      = '0;
        running_peak_next        = PEAK_FLOOR;
        bin_scaled_acc_next      = acc_t'({eff_cols, 1'b0});
        column_boundary_acc_next = BINS_ACC;
      end else begin
        current_column_next      = col_base + column_t'(1);
        running_peak_next        = PEAK_FLOOR;
        column_boundary_acc_next = cba_base + BINS_ACC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_we && cfg_index == REG_COLUMN_COUNT)) begin
      current_column      <= '0;
      running_peak        <= PEAK_FLOOR;
      bin_scaled_acc      <= acc_t'({effective_columns(
                               rst ? COLUMN_COUNT_RESET : cfg_data[CNT_W-1:0]), 1'b0});
      column_boundary_acc <= BINS_ACC;
    end else if (s1_valid && advance) begin
      current_column      <= current_column_next;
      running_peak        <= running_peak_next;
      bin_scaled_acc      <= bin_scaled_acc_next;
      column_boundary_acc <= column_boundary_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && col_end;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && col_end) begin
      pixel_value  <= make_pixel(peak_upd, display_offset);
      column_index <= col_base;
      last_column  <= col_last;
    end
  end

  `SPD_ASSERT(a_column_in_range, clk, rst, count_t'(current_column) < eff_cols)
  `SPD_ASSERT_NEXT(a_held_item_kept, clk, rst, s1_valid && !advance, s1_valid)
  `SPD_ASSERT_NEXT(a_count_write_restarts, clk, rst,
                   cfg_we && cfg_index == REG_COLUMN_COUNT,
                   current_column == '0 && column_boundary_acc == BINS_ACC)
  `SPD_ASSERT_NEXT(a_result_needs_item, clk, rst, !s1_valid && advance, !out_valid)

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Spectrum peak decimator testbench
// Streams spectrum bins through the decimator under random idling on both
// channels and checks every column byte against a cycle-free pooling model
// kept in step with the register writes.
// ---------------------------------------------------------------------------
module testbench;
  import spd_pkg::*;

  localparam int CYCLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    power_t power;
    logic   start;
  } bin_item_t;

  typedef struct {
    pixel_t  pixel;
    column_t column;
    logic    last;
  } column_byte_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  power_t               power_db = '0;
  logic                 frame_start = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pixel_t               pixel_value;
  column_t              column_index;
  logic                 last_column;
  logic                 cfg_we = 1'b0;
  reg_index_t           cfg_index = REG_COLUMN_COUNT;
  logic [CFG_W-1:0]     cfg_data = '0;

  bin_item_t    bins_to_send[$];
  column_byte_t pending_bytes[$];

  int  in_idle_pct = 33;
  int  out_idle_pct = 33;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  cycle_count = 0;
  int  errors = 0;
  int  bins_sent = 0;
  int  bytes_seen = 0;
  int  writes_done = 0;
  bit  in_taken = 1'b0;

  // pooling model state
  count_t  pool_cols_reg;
  offset_t pool_offset;
  column_t pool_col;
  power_t  pool_peak;
  acc_t    pool_bin_acc;
  acc_t    pool_edge_acc;

  spectrum_peak_decimator_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .power_db     (power_db),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_value  (pixel_value),
    .column_index (column_index),
    .last_column  (last_column),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic count_t active_columns();
    count_t c;
    c = pool_cols_reg;
    if (c == '0) c = count_t'(1);
    if (c > count_t'(4096)) c = count_t'(4096);
    return c;
  endfunction

  function automatic void frame_restart();
    pool_col = '0;
    pool_peak = PEAK_FLOOR;
    pool_bin_acc = acc_t'(2 * int'(active_columns()));
    pool_edge_acc = BINS_ACC;
  endfunction

  function automatic pixel_t column_pixel(power_t peak, offset_t ofs);
    int v;
    v = -(int'(peak) + int'(ofs));
    v = v / 16;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return pixel_t'(v);
  endfunction

  function automatic void pool_bin(power_t pwr, logic start);
    count_t       n;
    column_byte_t b;
    if (start) frame_restart();
    n = active_columns();
    if (pwr > pool_peak) pool_peak = pwr;
    if (pool_bin_acc > pool_edge_acc) begin
      b.pixel = column_pixel(pool_peak, pool_offset);
      b.column = pool_col;
      b.last = (int'(pool_col) + 1 >= int'(n));
      pending_bytes.push_back(b);
      if (b.last) begin
        frame_restart();
      end else begin
        pool_col = pool_col + column_t'(1);
        pool_edge_acc = pool_edge_acc + BINS_ACC;
        pool_peak = PEAK_FLOOR;
        pool_bin_acc = pool_bin_acc + acc_t'(n);
      end
    end else begin
      pool_bin_acc = pool_bin_acc + acc_t'(n);
    end
  endfunction

  // driver
  always @(negedge clk) begin : drv
    bin_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (bins_to_send.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt = bins_to_send.pop_front();
        power_db <= nxt.power;
        frame_start <= nxt.start;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    column_byte_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      in_taken = !rst && in_valid && in_ready;
      if (in_taken) begin
        pool_bin(power_db, frame_start);
        bins_sent++;
      end
      if (!rst && out_valid && out_ready) begin
        if (pending_bytes.size() == 0) begin
          $error("column byte %0d for column %0d with none expected",
                 pixel_value, column_index);
          errors++;
        end else begin
          want = pending_bytes.pop_front();
          bytes_seen++;
          if (pixel_value !== want.pixel) begin
            $error("pixel_value: expected %0d, got %0d", want.pixel, pixel_value);
            errors++;
          end
          if (column_index !== want.column) begin
            $error("column_index: expected %0d, got %0d", want.column, column_index);
            errors++;
          end
          if (last_column !== want.last) begin
            $error("last_column: expected %0d, got %0d", want.last, last_column);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_COLUMN_COUNT) begin
      pool_cols_reg = count_t'(data);
      frame_restart();
    end else begin
      pool_offset = offset_t'(data);
    end
    writes_done++;
  endtask

  task automatic wait_drained();
    while (bins_to_send.size() != 0 || in_valid || pending_bytes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_bin(int pwr, logic start);
    bin_item_t b;
    b.power = power_t'(pwr);
    b.start = start;
    bins_to_send.push_back(b);
  endtask

  function automatic int pick_power();
    int centre;
    centre = -int'(pool_offset);
    if ($urandom_range(3) == 0) return int'($urandom_range(65535));
    return centre - int'($urandom_range(4400)) + int'($urandom_range(200));
  endfunction

  task automatic run_frames(int count, bit open_frame, int start_pct);
    for (int i = 0; i < count; i++)
      send_bin(pick_power(), (i == 0 && open_frame) || ($urandom_range(99) < start_pct));
    wait_drained();
  endtask

  initial begin
    pool_cols_reg = COLUMN_COUNT_RESET;
    pool_offset = DISPLAY_OFFSET_RESET;
    frame_restart();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: one bin per column at reset settings
    send_bin(32767, 1'b1);
    send_bin(-32768, 1'b0);
    send_bin(0, 1'b0);
    send_bin(-1, 1'b0);
    send_bin(1, 1'b0);
    send_bin(768, 1'b0);
    send_bin(767, 1'b0);
    send_bin(753, 1'b0);
    send_bin(752, 1'b0);
    send_bin(-3311, 1'b0);
    send_bin(-3312, 1'b0);
    send_bin(-3327, 1'b0);
    send_bin(-3328, 1'b0);
    send_bin(-1000, 1'b1);
    send_bin(-2000, 1'b0);
    send_bin(-32767, 1'b1);
    send_bin(32766, 1'b0);
    send_bin(-16384, 1'b0);
    send_bin(16384, 1'b0);
    send_bin(-769, 1'b0);
    wait_drained();

    // column count of zero acts as one column; the open column is dropped
    // by the next count write
    write_reg(REG_COLUMN_COUNT, CFG_W'(0));
    write_reg(REG_DISPLAY_OFFSET, CFG_W'(-768));
    run_frames(20, 1'b1, 0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_COLUMN_COUNT, CFG_W'(8191));
          write_reg(REG_DISPLAY_OFFSET, CFG_W'(32767));
        end
        1: begin
          in_idle_pct = 0;
          out_idle_pct = 0;
          write_reg(REG_COLUMN_COUNT, CFG_W'(4096));
          write_reg(REG_DISPLAY_OFFSET, CFG_W'(-32768));
        end
        2: begin
          in_idle_pct = 33;
          out_idle_pct = 33;
          write_reg(REG_COLUMN_COUNT, CFG_W'(4095));
          write_reg(REG_DISPLAY_OFFSET, CFG_W'($urandom_range(65535)));
          hold_req++;
        end
        3: begin
          write_reg(REG_COLUMN_COUNT, CFG_W'($urandom_range(4096, 2048)));
          write_reg(REG_DISPLAY_OFFSET, CFG_W'(0));
        end
        4: write_reg(REG_DISPLAY_OFFSET, CFG_W'(-int'($urandom_range(2000))));
        5: write_reg(REG_COLUMN_COUNT, CFG_W'($urandom_range(8191, 4097)));
        6: begin
          write_reg(REG_COLUMN_COUNT, CFG_W'(3000));
          write_reg(REG_DISPLAY_OFFSET, CFG_W'(-768));
        end
        default: begin
          write_reg(REG_COLUMN_COUNT, CFG_W'(4096));
          write_reg(REG_DISPLAY_OFFSET, CFG_W'($urandom_range(65535)));
        end
      endcase
      // offset-only phase carries on the frame left open before it
      run_frames(110, ph != 4, (ph == 5) ? 30 : 2);
    end

    wait_drained();
    $display("Sent %0d bins over %0d register writes and checked %0d column bytes,",
             bins_sent, writes_done, bytes_seen);
    $display("with clamped column counts, offset extremes and restarted frames.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/spd_pkg.sv
design/spectrum_peak_decimator_top.sv
sim/testbench.sv
